// ----- rtl/dhs_pkg.sv -----
package dhs_pkg;

    localparam int LEN_W = 4;
    localparam int SYM_W = 24;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic hash_step;
        logic probe_rd;
        logic probe_next;
        logic clear_wr;
        logic post;
        logic write_key;
        logic res_found;
        logic res_full;
    } dhs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hash_done;
        logic hit;
        logic empty;
        logic last_probe;
        logic clear_last;
        logic out_free;
        logic is_insert;
    } dhs_stat_t;

endpackage

// ----- rtl/dhs_if.sv -----
interface dhs_req_if;
    import dhs_pkg::*;

    logic             valid;
    logic             ready;
    logic             command;
    logic [LEN_W-1:0] length;
    logic [SYM_W-1:0] symbols;

    modport source (output valid, command, length, symbols, input ready);
    modport sink (input valid, command, length, symbols, output ready);
endinterface

interface dhs_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic table_full;

    modport source (output valid, found, table_full, input ready);
    modport sink (input valid, found, table_full, output ready);
endinterface

// ----- rtl/dhs_ctrl.sv -----
module dhs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  dhs_pkg::dhs_stat_t stat,
    output dhs_pkg::dhs_cmd_t  cmd,
    output logic              ready
);
    import dhs_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (stat.hash_done)
                begin
                    cmd.probe_rd = 1'b1;
                    state_next   = ST_CHECK;
                end
                else
                begin
                    cmd.hash_step = 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.hit || stat.empty || stat.last_probe)
                begin
                    // hold here (read data stays) until the output slot is free
                    if (stat.out_free)
                    begin
                        cmd.post      = 1'b1;
                        cmd.res_found = stat.hit;
                        cmd.res_full  = !stat.hit && !stat.empty;
                        cmd.write_key = !stat.hit && stat.empty && stat.is_insert;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/dhs_dpath.sv -----
module dhs_dpath #(
    parameter int TABLE_SIZE  = 1021,
    parameter int MAX_SYMBOLS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dhs_pkg::dhs_cmd_t         cmd,
    output dhs_pkg::dhs_stat_t        stat,
    input  logic                      req_command,
    input  logic [dhs_pkg::LEN_W-1:0] req_length,
    input  logic [dhs_pkg::SYM_W-1:0] req_symbols,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic                      rsp_found,
    output logic                      rsp_table_full
);
    import dhs_pkg::*;

    // bits of 5^n - 1, the largest key of n symbols
    function automatic int key_width(input int n);
        longint v;
        int     w;
        v = 1;
        w = 0;
        for (int i = 0; i < n; i++)
        begin
            v = v * 5;
        end
        v = v - 1;
        while (v > 0)
        begin
            w++;
            v = v >>> 1;
        end
        return (w < 1) ? 1 : w;
    endfunction

    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam int NSYM    = (MAX_SYMBOLS < LEN_MAX) ? MAX_SYMBOLS : LEN_MAX;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(NSYM);
    localparam int KEY_W   = key_width(NSYM);
    localparam int AW      = $clog2(TABLE_SIZE);
    localparam int RW      = AW + 3;
    localparam int XW      = 32;

    // x < 6m on entry; result < m
    function automatic logic [RW-1:0] mod_reduce(input logic [RW-1:0] x,
                                                 input logic [RW-1:0] m);
        logic [RW-1:0] r;
        r = x;
        if (r >= (m << 2))
        begin
            r = r - (m << 2);
        end
        if (r >= (m << 1))
        begin
            r = r - (m << 1);
        end
        if (r >= m)
        begin
            r = r - m;
        end
        return r;
    endfunction

    logic             cmd_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic [KEY_W-1:0] key_reg;
    logic [AW-1:0]    pos_reg;
    logic [AW-1:0]    stp_reg;
    logic [AW-1:0]    prb_reg;
    logic [AW-1:0]    clr_addr_reg;
    logic [KEY_W:0]   rd_reg;
    logic             out_valid_reg;
    logic             found_reg;
    logic             full_reg;

    logic [AW-1:0]    pos_next;
    logic [AW-1:0]    stp_next;
    logic [KEY_W-1:0] key_next;
    logic [AW-1:0]    adv_pos;
    logic [AW:0]      adv_sum;
    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] sym_idx;
    logic [XW-1:0]    sym_ext;
    logic [2:0]       code;
    logic [RW-1:0]    pos_x;
    logic [RW-1:0]    stp_x;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [KEY_W:0]   mem_wdata;

    logic [KEY_W:0]   mem [TABLE_SIZE];

    assign len_sat = (req_length > LEN_CAP) ? LEN_CAP : req_length;
    assign sym_idx = cnt_reg - LEN_W'(1);
    assign sym_ext = XW'(sym_reg);
    assign code    = {1'b0, sym_ext[{sym_idx, 1'b0} +: 2]} + 3'd1;

    // Horner step, most significant symbol first; both residues track the key
    assign key_next = (key_reg << 2) + key_reg + KEY_W'(code);
    assign pos_x    = (RW'(pos_reg) << 2) + RW'(pos_reg) + RW'(code);
    assign stp_x    = (RW'(stp_reg) << 2) + RW'(stp_reg) + RW'(code);
    assign pos_next = AW'(mod_reduce(pos_x, RW'(TABLE_SIZE)));
    assign stp_next = AW'(mod_reduce(stp_x, RW'(TABLE_SIZE - 1)));

    // stride is stp_reg + 1, below the table size
    assign adv_sum = (AW+1)'(pos_reg) + (AW+1)'(stp_reg) + (AW+1)'(1);
    assign adv_pos = (adv_sum >= (AW+1)'(TABLE_SIZE)) ?
                     AW'(adv_sum - (AW+1)'(TABLE_SIZE)) : AW'(adv_sum);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= req_command;
            sym_reg <= req_symbols;
            cnt_reg <= len_sat;
            key_reg <= '0;
            pos_reg <= '0;
            stp_reg <= '0;
            prb_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            cnt_reg <= sym_idx;
            key_reg <= key_next;
            pos_reg <= pos_next;
            stp_reg <= stp_next;
        end
        else if (cmd.probe_next)
        begin
            pos_reg <= adv_pos;
            prb_reg <= prb_reg + AW'(1);
        end
        if (cmd.post)
        begin
            found_reg <= cmd.res_found;
            full_reg  <= cmd.res_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.post)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // slot word: {valid, key}
    assign mem_we    = cmd.clear_wr || cmd.write_key;
    assign mem_waddr = cmd.clear_wr ? clr_addr_reg : pos_reg;
    assign mem_wdata = cmd.clear_wr ? '0 : {1'b1, key_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.probe_rd)
        begin
            rd_reg <= mem[pos_reg];
        end
    end

    assign stat.hash_done  = (cnt_reg == '0);
    assign stat.hit        = rd_reg[KEY_W] && (rd_reg[KEY_W-1:0] == key_reg);
    assign stat.empty      = !rd_reg[KEY_W];
    assign stat.last_probe = (prb_reg == AW'(TABLE_SIZE - 1));
    assign stat.clear_last = (clr_addr_reg == AW'(TABLE_SIZE - 1));
    assign stat.out_free   = !out_valid_reg || rsp_ready;
    assign stat.is_insert  = (cmd_reg != CMD_FIND);

    assign rsp_valid      = out_valid_reg;
    assign rsp_found      = found_reg;
    assign rsp_table_full = full_reg;

    a_write_insert_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_key |-> (cmd_reg == CMD_INSERT) && !cmd.clear_wr)
        else $error("key write outside an insert");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_rd |-> ({1'b0, pos_reg} < (AW+1)'(TABLE_SIZE)) &&
                         (stp_reg < AW'(TABLE_SIZE - 1)))
        else $error("probe address or stride out of range");

    a_post_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> (!out_valid_reg || rsp_ready))
        else $error("result overwrites a pending word");

    a_full_after_all: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.post && cmd.res_full) |-> stat.last_probe && !stat.hit && !stat.empty)
        else $error("full reported before the table was exhausted");

endmodule

// ----- rtl/double_hash_set_insert_find_top.sv -----
// Set of DNA strings (up to MAX_SYMBOLS symbols) kept as base-5 keys in an
// open-addressing table of TABLE_SIZE slots with double hashing. Insert
// (command 0) stores the key if absent; find (command 1) only reads. Each
// request returns one word: found, and table_full when TABLE_SIZE probes met
// neither the key nor a free slot. After reset the table is swept clear one
// slot per cycle, and no request is taken during the sweep. The key and both
// hash residues are built one symbol per cycle, and each probe is a read of
// the slot memory followed by a compare. One request is in flight at a time;
// the next is taken while the previous result waits.
module double_hash_set_insert_find_top #(
    parameter int TABLE_SIZE  = 1021,
    parameter int MAX_SYMBOLS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    dhs_req_if.sink   req,
    dhs_rsp_if.source rsp
);
    import dhs_pkg::*;

    dhs_cmd_t  cmd;
    dhs_stat_t stat;
    logic      ctl_ready;

    dhs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .stat      (stat),
        .cmd       (cmd),
        .ready     (ctl_ready)
    );

    dhs_dpath #(
        .TABLE_SIZE  (TABLE_SIZE),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_command    (req.command),
        .req_length     (req.length),
        .req_symbols    (req.symbols),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_found      (rsp.found),
        .rsp_table_full (rsp.table_full)
    );

    assign req.ready = ctl_ready;

endmodule

// ----- bench/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dhs_pkg::*;

    localparam int TABLE_SIZE   = 1021;
    localparam int MAX_SYMBOLS  = 12;
    localparam int PHASES       = 4;
    localparam int PHASE_WORDS  = 407;
    localparam int STALL_LIMIT  = 12000;
    localparam int TAIL_CYCLES  = 40;
    localparam int N_DIRECTED   = 21;

    typedef struct packed {
        logic found;
        logic table_full;
    } set_reply_t;

    typedef struct packed {
        logic             command;
        logic [LEN_W-1:0] length;
        logic [SYM_W-1:0] symbols;
        logic             typed;
        set_reply_t       reply;
    } request_row_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [SYM_W-1:0] symbols;
    } dna_string_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dhs_req_if req_bus ();
    dhs_rsp_if rsp_bus ();

    double_hash_set_insert_find_top #(
        .TABLE_SIZE  (TABLE_SIZE),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #5 clk = ~clk;

    // shadow of the slot memory
    int unsigned  shadow_key  [TABLE_SIZE];
    bit           shadow_used [TABLE_SIZE];
    int           shadow_fill = 0;

    set_reply_t   replies_due [$];
    dna_string_t  stored_strings [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    int idle_by_phase  [PHASES] = '{0, 66, 0, 22};
    int stall_by_phase [PHASES] = '{0, 0, 66, 22};

    // typed replies only where they follow directly from the rows above them
    request_row_t directed_rows [N_DIRECTED] = '{
        '{CMD_FIND,   4'd1,  24'h000000, 1'b1, '{1'b0, 1'b0}},
        '{CMD_FIND,   4'd0,  24'hFFFFFF, 1'b1, '{1'b0, 1'b0}},
        '{CMD_INSERT, 4'd0,  24'h000000, 1'b1, '{1'b0, 1'b0}},
        '{CMD_FIND,   4'd0,  24'hABCDEF, 1'b1, '{1'b1, 1'b0}},
        '{CMD_INSERT, 4'd0,  24'hFFFFFF, 1'b1, '{1'b1, 1'b0}},
        '{CMD_INSERT, 4'd1,  24'h000000, 1'b1, '{1'b0, 1'b0}},
        '{CMD_FIND,   4'd1,  24'hFFFFFC, 1'b1, '{1'b1, 1'b0}},
        '{CMD_INSERT, 4'd2,  24'h000000, 1'b0, '{1'b0, 1'b0}},
        '{CMD_INSERT, 4'd12, 24'hFFFFFF, 1'b0, '{1'b0, 1'b0}},
        '{CMD_FIND,   4'd15, 24'hFFFFFF, 1'b1, '{1'b1, 1'b0}},
        '{CMD_INSERT, 4'd13, 24'hFFFFFF, 1'b1, '{1'b1, 1'b0}},
        '{CMD_FIND,   4'd12, 24'h000000, 1'b0, '{1'b0, 1'b0}},
        '{CMD_INSERT, 4'd12, 24'h000000, 1'b0, '{1'b0, 1'b0}},
        '{CMD_FIND,   4'd14, 24'h000000, 1'b1, '{1'b1, 1'b0}},
        // GGAAG: key 2043, same first slot as A, so it takes a second probe
        '{CMD_INSERT, 4'd5,  24'h00020A, 1'b0, '{1'b0, 1'b0}},
        '{CMD_FIND,   4'd5,  24'hFFFE0A, 1'b1, '{1'b1, 1'b0}},
        '{CMD_FIND,   4'd5,  24'h00020B, 1'b0, '{1'b0, 1'b0}},
        '{CMD_INSERT, 4'd4,  24'hFFFFFF, 1'b0, '{1'b0, 1'b0}},
        '{CMD_FIND,   4'd3,  24'hFFFFFF, 1'b0, '{1'b0, 1'b0}},
        '{CMD_INSERT, 4'd1,  24'h000003, 1'b0, '{1'b0, 1'b0}},
        '{CMD_FIND,   4'd1,  24'h000003, 1'b1, '{1'b1, 1'b0}}
    };

    function automatic int unsigned dna_key(logic [LEN_W-1:0] len, logic [SYM_W-1:0] sym);
        int unsigned n;
        int unsigned key;
        int unsigned weight;
        n = (len > MAX_SYMBOLS) ? MAX_SYMBOLS : len;
        key = 0;
        weight = 1;
        for (int j = 0; j < n; j++)
        begin
            key += weight * (32'(sym[2*j +: 2]) + 1);
            weight *= 5;
        end
        return key;
    endfunction

    function automatic set_reply_t apply_request(logic command, logic [LEN_W-1:0] len,
                                                 logic [SYM_W-1:0] sym);
        int unsigned key;
        int unsigned pos;
        int unsigned stride;
        set_reply_t  reply;
        key = dna_key(len, sym);
        pos = key % TABLE_SIZE;
        stride = 1 + key % (TABLE_SIZE - 1);
        reply.found = 1'b0;
        reply.table_full = 1'b1;
        for (int probe = 0; probe < TABLE_SIZE; probe++)
        begin
            if (shadow_used[pos] && shadow_key[pos] == key)
            begin
                reply.found = 1'b1;
                reply.table_full = 1'b0;
                break;
            end
            if (!shadow_used[pos])
            begin
                if (command == CMD_INSERT)
                begin
                    shadow_used[pos] = 1'b1;
                    shadow_key[pos] = key;
                    shadow_fill++;
                    stored_strings.push_back('{len, sym});
                end
                reply.table_full = 1'b0;
                break;
            end
            pos += stride;
            if (pos >= TABLE_SIZE)
                pos -= TABLE_SIZE;
        end
        return reply;
    endfunction

    task automatic send_request(input logic command, input logic [LEN_W-1:0] len,
                                input logic [SYM_W-1:0] sym, input logic typed,
                                input set_reply_t typed_reply);
        set_reply_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.command <= command;
        req_bus.length  <= len;
        req_bus.symbols <= sym;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predicted = apply_request(command, len, sym);
        replies_due.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic send_random_request();
        dna_string_t      pick;
        logic             command;
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] sym;
        int               fresh_pct;
        int               kind;
        // once the table is full, misses cost a full probe sweep: keep them few
        fresh_pct = (shadow_fill < TABLE_SIZE) ? 78 : 25;
        sym = SYM_W'($urandom);
        command = CMD_INSERT;
        if ($urandom_range(99) < fresh_pct)
        begin
            len = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(5, 11)) : LEN_W'(MAX_SYMBOLS);
        end
        else
        begin
            kind = $urandom_range(99);
            if (kind < 60 && stored_strings.size() > 0)
            begin
                // same string again; bits past its last symbol are scrambled
                pick = stored_strings[$urandom_range(stored_strings.size() - 1)];
                command = 1'($urandom_range(1));
                len = pick.length;
                if (len >= MAX_SYMBOLS)
                    len = LEN_W'($urandom_range(MAX_SYMBOLS, 15));
                for (int j = 0; j < SYM_W / 2; j++)
                begin
                    if (j < len)
                        sym[2*j +: 2] = pick.symbols[2*j +: 2];
                end
            end
            else if (kind < 80)
            begin
                command = CMD_FIND;
                len = LEN_W'($urandom_range(1, 15));
            end
            else
            begin
                command = 1'($urandom_range(1));
                len = $urandom_range(1) ? LEN_W'($urandom_range(0, 3)) : LEN_W'($urandom_range(15));
            end
        end
        send_request(command, len, sym, 1'b0, '0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : reply_check
        set_reply_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (replies_due.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word, expected none, got found=%b table_full=%b",
                         $time, rsp_bus.found, rsp_bus.table_full);
            end
            else
            begin
                want = replies_due.pop_front();
                if (rsp_bus.found !== want.found)
                begin
                    error_count++;
                    $display("%0t: found mismatch, expected %b, got %b",
                             $time, want.found, rsp_bus.found);
                end
                if (rsp_bus.table_full !== want.table_full)
                begin
                    error_count++;
                    $display("%0t: table_full mismatch, expected %b, got %b",
                             $time, want.table_full, rsp_bus.table_full);
                end
            end
        end
    end

    // covers the clear sweep after reset and a full probe sweep on a full table
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        req_bus.valid   = 1'b0;
        req_bus.command = CMD_INSERT;
        req_bus.length  = '0;
        req_bus.symbols = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].command, directed_rows[i].length,
                         directed_rows[i].symbols, directed_rows[i].typed,
                         directed_rows[i].reply);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // hold off until the block has returned every word
            req_bus.valid <= 1'b0;
            while (replies_due.size() != 0)
                @(posedge clk);
            send_idle_pct  = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            repeat (PHASE_WORDS)
                send_random_request();
        end

        req_bus.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
